// File: sv/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and constants shared by the periodic task dispatcher modules.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int TIME_W     = 32;
  localparam int RESULT_CAP = 8;
  localparam int N_W        = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_START   = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_SUSPEND = 3'd3,
    KIND_RESUME  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_READY      = 2'd0,
    ST_BLOCKED    = 2'd1,
    ST_TERMINATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MODIFY,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RD_SLOT,
    RD_FIRST,
    RD_NEXT
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_START,
    WR_MODIFY,
    WR_STAMP
  } wr_src_t;

  typedef enum logic [2:0] {
    RES_FAIL,
    RES_FAIL_SLOT,
    RES_START,
    RES_OK_SLOT,
    RES_NONE_DUE,
    RES_DUE,
    RES_DUE_LAST
  } res_t;

  typedef struct packed {
    logic              active;
    status_t           status;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_run;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    ram_rd;
    rd_src_t rd_src;
    logic    ram_wr;
    wr_src_t wr_src;
    logic    cnt_inc;
    logic    scan_clr;
    logic    scan_adv;
    logic    take_pend;
    logic    emit;
    res_t    res;
  } ptd_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  slot_bad;
    logic  cnt_zero;
    logic  due;
    logic  have_pend;
    logic  scan_end;
    logic  cap_hit;
    logic  out_free;
  } ptd_stat_t;

endpackage

// File: sv/ptd_ram.sv
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/ptd_dpath.sv
// ----------------------------------------------------------------------------
// ptd_dpath
// Request registers, task count, slot table, scan pointer and result register.
// ----------------------------------------------------------------------------
module ptd_dpath import ptd_pkg::*; #(
  parameter int MAX_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KIND_W-1:0] kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [TIME_W-1:0] interval,
  input  logic [TIME_W-1:0] now_ms,
  input  ptd_cmd_t          cmd,
  output ptd_stat_t         stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              ok,
  output logic [SLOT_W-1:0] task_slot,
  output logic              task_due,
  output logic              last
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [KIND_W-1:0] item_kind;
  logic [SLOT_W-1:0] item_slot;
  logic [TIME_W-1:0] item_interval;
  logic [TIME_W-1:0] item_now;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  pend;
  logic              have_pend;
  logic [N_W-1:0]    n;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] rd_word;
  logic [TIME_W-1:0] elapsed;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind     <= kind;
      item_slot     <= slot;
      item_interval <= interval;
      item_now      <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      pend      <= '0;
      have_pend <= 1'b0;
      n         <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.scan_clr) begin
        idx       <= '0;
        have_pend <= 1'b0;
        n         <= '0;
      end else begin
        if (cmd.take_pend) begin
          pend      <= idx;
          have_pend <= 1'b1;
          n         <= n + N_W'(1);
        end
        if (cmd.scan_adv) begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    case (cmd.rd_src)
      RD_SLOT:  rd_addr = IDX_W'(item_slot);
      RD_FIRST: rd_addr = '0;
      RD_NEXT:  rd_addr = idx + IDX_W'(1);
      default:  rd_addr = '0;
    endcase
  end

  assign rd_entry = rd_word;

  always_comb begin
    wr_entry = rd_entry;
    case (cmd.wr_src)
      WR_START: begin
        wr_addr           = IDX_W'(count);
        wr_entry.active   = 1'b1;
        wr_entry.status   = ST_READY;
        wr_entry.period   = item_interval;
        wr_entry.last_run = '0;
      end
      WR_MODIFY: begin
        wr_addr = IDX_W'(item_slot);
        case (kind_t'(item_kind))
          KIND_STOP: begin
            wr_entry.active = 1'b0;
            wr_entry.status = ST_TERMINATED;
          end
          KIND_SUSPEND: wr_entry.status = ST_BLOCKED;
          KIND_RESUME:  wr_entry.status = ST_READY;
          default:      wr_entry.status = rd_entry.status;
        endcase
      end
      WR_STAMP: begin
        wr_addr           = idx;
        wr_entry.last_run = item_now;
      end
      default: wr_addr = idx;
    endcase
  end

  ptd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.ram_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign elapsed  = item_now - rd_entry.last_run;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.kind      = kind_t'(item_kind);
    stat.full      = (count == CNT_W'(MAX_SLOTS));
    stat.slot_bad  = (CMP_W'(item_slot) >= CMP_W'(count));
    stat.cnt_zero  = (count == '0);
    stat.due       = rd_entry.active && (rd_entry.status == ST_READY) &&
                     (elapsed >= rd_entry.period);
    stat.have_pend = have_pend;
    stat.scan_end  = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.cap_hit   = (n == N_W'(RESULT_CAP - 1));
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res)
        RES_FAIL_SLOT: begin
          ok <= 1'b0; task_slot <= item_slot; task_due <= 1'b0; last <= 1'b1;
        end
        RES_START: begin
          ok <= 1'b1; task_slot <= SLOT_W'(count); task_due <= 1'b0; last <= 1'b1;
        end
        RES_OK_SLOT: begin
          ok <= 1'b1; task_slot <= item_slot; task_due <= 1'b0; last <= 1'b1;
        end
        RES_NONE_DUE: begin
          ok <= 1'b1; task_slot <= '0; task_due <= 1'b0; last <= 1'b1;
        end
        RES_DUE: begin
          ok <= 1'b1; task_slot <= SLOT_W'(pend); task_due <= 1'b1; last <= 1'b0;
        end
        RES_DUE_LAST: begin
          ok <= 1'b1; task_slot <= SLOT_W'(pend); task_due <= 1'b1; last <= 1'b1;
        end
        default: begin
          ok <= 1'b0; task_slot <= '0; task_due <= 1'b0; last <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: sv/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Request sequencer: decode, read-modify-write of a slot, and the tick scan.
// ----------------------------------------------------------------------------
module ptd_ctrl import ptd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ptd_stat_t stat,
  output ptd_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic go;
    go         = 1'b0;
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.out_free) begin
          case (stat.kind)
            KIND_TICK: begin
              if (stat.cnt_zero) begin
                cmd.emit   = 1'b1;
                cmd.res    = RES_NONE_DUE;
                state_next = S_IDLE;
              end else begin
                cmd.scan_clr = 1'b1;
                cmd.ram_rd   = 1'b1;
                cmd.rd_src   = RD_FIRST;
                state_next   = S_SCAN;
              end
            end
            KIND_START: begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (stat.full) begin
                cmd.res = RES_FAIL;
              end else begin
                cmd.res     = RES_START;
                cmd.ram_wr  = 1'b1;
                cmd.wr_src  = WR_START;
                cmd.cnt_inc = 1'b1;
              end
            end
            KIND_STOP, KIND_SUSPEND, KIND_RESUME: begin
              if (stat.slot_bad) begin
                cmd.emit   = 1'b1;
                cmd.res    = RES_FAIL_SLOT;
                state_next = S_IDLE;
              end else begin
                cmd.ram_rd = 1'b1;
                cmd.rd_src = RD_SLOT;
                state_next = S_MODIFY;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.res    = RES_FAIL;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_MODIFY: begin
        if (stat.out_free) begin
          cmd.ram_wr = 1'b1;
          cmd.wr_src = WR_MODIFY;
          cmd.emit   = 1'b1;
          cmd.res    = RES_OK_SLOT;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        go = !(stat.due && stat.have_pend) || stat.out_free;
        if (go) begin
          if (stat.due) begin
            cmd.ram_wr    = 1'b1;
            cmd.wr_src    = WR_STAMP;
            cmd.take_pend = 1'b1;
            if (stat.have_pend) begin
              cmd.emit = 1'b1;
              cmd.res  = RES_DUE;
            end
          end
          if ((stat.due && stat.cap_hit) || stat.scan_end) begin
            state_next = S_FLUSH;
          end else begin
            cmd.ram_rd   = 1'b1;
            cmd.rd_src   = RD_NEXT;
            cmd.scan_adv = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.res    = stat.have_pend ? RES_DUE_LAST : RES_NONE_DUE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: sv/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core
// Start: result registered from the dispatch state. Stop, suspend, resume: a valid slot is read,
// then written back with the result from the modify state. Tick: one slot per cycle through the
// table read port unless an output stall holds a due result; with no tasks the tick result comes
// from the dispatch state. One request at a time; the next is taken once the last result is
// registered. Output stalls add cycles. Reset clears the task count, no table clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_core import ptd_pkg::*; #(
  parameter int MAX_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [TIME_W-1:0] interval,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [SLOT_W-1:0] task_slot,
  output logic              task_due,
  output logic              last
);

  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptd_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .slot      (slot),
    .interval  (interval),
    .now_ms    (now_ms),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .ok        (ok),
    .task_slot (task_slot),
    .task_due  (task_due),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written while output register is held");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("task count advanced past table size");
`endif

endmodule
